FILE: rtl/per_neighbor_hello_flood_detector_macros.svh
// Assertion macros shared by the hello flood detector RTL.
// Each macro checks on the rising edge of clk, disabled while rst_n is low.
`ifndef PER_NEIGHBOR_HELLO_FLOOD_DETECTOR_MACROS_SVH
`define PER_NEIGHBOR_HELLO_FLOOD_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every edge out of reset
`define PNHFD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PNHFD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define PNHFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PNHFD_ASSERT_ALWAYS(lbl, cond, msg)
`define PNHFD_ASSERT_IMPLY(lbl, ante, cons, msg)
`define PNHFD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/pnhfd_pkg.sv
// Types and constants of the hello flood detector.
// No dependencies; used by the interfaces, the cell and the top level.
package pnhfd_pkg;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned TIME_W   = 48;
    localparam int unsigned WLEN_W   = 32;
    localparam int unsigned MAXH_W   = 8;
    localparam int unsigned COUNT_W  = 9;
    localparam int unsigned SLOT_W   = 8;   // holds any index up to 255
    localparam int unsigned OSLOT_W  = 4;   // slot as reported on the result
    localparam int unsigned CFG_W    = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX      = 9'd511;
    localparam logic [WLEN_W-1:0]  WLEN_RESET     = 32'd1000000;
    localparam logic [MAXH_W-1:0]  MAXH_RESET     = 8'd10;
    localparam logic               MODE_HELLO     = 1'b0;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WATCH = 2'd1,
        PH_ALERT = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_EXISTING = 2'd0,
        ST_NEW      = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic {
        CFG_WINDOW_LENGTH = 1'b0,
        CFG_MAX_HELLOS    = 1'b1
    } cfg_idx_t;

    // lookup token handed from cell to cell
    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] wend;      // saturated now + window length
        logic              found;
        logic              fresh;
        logic              malicious;
        logic              raised;
        logic [SLOT_W-1:0] slot;
    } tok_t;

    // finished result beat
    typedef struct packed {
        logic               malicious;
        logic               alert_raised;
        status_t            lookup_status;
        logic [OSLOT_W-1:0] entry_slot;
    } res_t;

endpackage

FILE: rtl/pnhfd_if.sv
// Valid/ready channel interfaces for item and result beats.
// Depends on pnhfd_pkg for field widths.
interface pnhfd_in_if
    import pnhfd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [ADDR_W-1:0] neighbor_address;
    logic [TIME_W-1:0] now_time;

    modport source (output valid, mode, neighbor_address, now_time, input ready);
    modport sink   (input valid, mode, neighbor_address, now_time, output ready);
endinterface

interface pnhfd_out_if
    import pnhfd_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               malicious;
    logic               alert_raised;
    logic [1:0]         lookup_status;
    logic [OSLOT_W-1:0] entry_slot;

    modport source (output valid, malicious, alert_raised, lookup_status, entry_slot,
                    input ready);
    modport sink   (input valid, malicious, alert_raised, lookup_status, entry_slot,
                    output ready);
endinterface

FILE: rtl/pnhfd_cell.sv
// One neighbor entry of the table and one stage of the lookup chain.
// Depends on pnhfd_pkg.
module pnhfd_cell
    import pnhfd_pkg::*;
#(
    parameter int unsigned CELL_INDEX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [MAXH_W-1:0] max_hellos,
    input  logic              tok_vld_in,
    input  tok_t              tok_in,
    output logic              tok_vld_out,
    output tok_t              tok_out,
    output logic              entry_valid
);

    logic              valid_reg, valid_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    phase_t            phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TIME_W-1:0] wend_reg, wend_next;
    logic              tok_vld_reg;
    tok_t              tok_reg, tok_next;

    logic               hit, take, expired;
    phase_t             cur_phase;
    logic [COUNT_W-1:0] cnt_inc;

    // match or claim this entry, then apply the hello
    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        addr_next  = addr_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        wend_next  = wend_reg;

        hit     = tok_vld_in && !tok_in.found && valid_reg && (addr_reg == tok_in.addr);
        take    = tok_vld_in && !tok_in.found && !valid_reg;
        expired = (phase_reg == PH_WATCH) && (wend_reg < tok_in.now);
        cur_phase = (take || expired) ? PH_IDLE : phase_reg;
        cnt_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

        if (hit || take)
        begin
            tok_next.found  = 1'b1;
            tok_next.fresh  = take;
            tok_next.raised = 1'b0;
            tok_next.slot   = SLOT_W'(CELL_INDEX);
            if (take)
            begin
                valid_next = 1'b1;
                addr_next  = tok_in.addr;
                phase_next = PH_IDLE;
                count_next = '0;
                wend_next  = '0;
            end
            if (tok_in.mode == MODE_HELLO)
            begin
                case (cur_phase)
                    PH_IDLE:
                    begin
                        phase_next = PH_WATCH;
                        count_next = COUNT_W'(1);
                        wend_next  = tok_in.wend;
                    end
                    PH_WATCH:
                    begin
                        count_next = cnt_inc;
                        if (cnt_inc > {1'b0, max_hellos})
                        begin
                            phase_next      = PH_ALERT;
                            tok_next.raised = 1'b1;
                        end
                    end
                    default:
                    begin
                        // alert is permanent
                    end
                endcase
            end
            tok_next.malicious = (phase_next == PH_ALERT);
        end
    end

    // entry valid bit and token valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            tok_vld_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            tok_vld_reg <= tok_vld_in;
        end
    end

    // entry payload and token payload
    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        phase_reg <= phase_next;
        count_reg <= count_next;
        wend_reg  <= wend_next;
        tok_reg   <= tok_next;
    end

    assign tok_vld_out = tok_vld_reg;
    assign tok_out     = tok_reg;
    assign entry_valid = valid_reg;

endmodule

FILE: rtl/per_neighbor_hello_flood_detector.sv
// Hello flood detector top level: launch stage, chain of table cells, result buffer.
// Depends on pnhfd_pkg, pnhfd_if, pnhfd_cell and the assertion macro header.
//
// Usage:
//   in_ch carries one item per beat: mode (0 hello, 1 query), neighbor_address
//   and now_time. out_ch returns exactly one result beat per item: malicious,
//   alert_raised, lookup_status and entry_slot.
//   cfg_we/cfg_index/cfg_data write window_length (index 0) and
//   max_hellos_in_window (index 1); write only while the block is idle.
//   Each item is launched into a row of TABLE_ENTRIES cells; the lookup token
//   steps one cell per cycle; its result is registered in the result buffer and
//   then in the output register that drives out_ch. One item is in flight at
//   a time: the next item is accepted once the last result leaves the buffer.
//   Reset empties the table (all entries free) and loads the register
//   defaults (1000000 and 10).
//   While out_ch is stalled the held result stays on the port; the next item
//   is still accepted and its result waits in a one-beat buffer until the
//   port frees up.
`include "per_neighbor_hello_flood_detector_macros.svh"

module per_neighbor_hello_flood_detector
    import pnhfd_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    pnhfd_in_if.sink            in_ch,
    pnhfd_out_if.source         out_ch,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    logic [WLEN_W-1:0] window_length_reg;
    logic [MAXH_W-1:0] max_hellos_reg;

    logic busy_reg, busy_next;
    logic launch_vld_reg;
    tok_t launch_tok_reg;
    logic pend_vld_reg, pend_vld_next;
    res_t pend_reg;
    logic out_vld_reg, out_vld_next;
    res_t out_reg;

    logic               in_accept, pend_move;
    logic [TIME_W:0]    wend_sum;
    logic [TIME_W-1:0]  wend_sat;
    res_t               exit_res;

    logic [TABLE_ENTRIES:0]   chain_vld;
    tok_t                     chain_tok [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] entry_vld;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WLEN_RESET;
            max_hellos_reg    <= MAXH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WINDOW_LENGTH: window_length_reg <= cfg_data[WLEN_W-1:0];
                CFG_MAX_HELLOS:    max_hellos_reg    <= cfg_data[MAXH_W-1:0];
            endcase
        end
    end

    // input handshake and window end with saturation
    assign in_accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !busy_reg;
    assign wend_sum = {1'b0, in_ch.now_time} + {{(TIME_W+1-WLEN_W){1'b0}}, window_length_reg};
    assign wend_sat = wend_sum[TIME_W] ? {TIME_W{1'b1}} : wend_sum[TIME_W-1:0];

    // launch stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_vld_reg <= 1'b0;
        end
        else
        begin
            launch_vld_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            launch_tok_reg.mode      <= in_ch.mode;
            launch_tok_reg.addr      <= in_ch.neighbor_address;
            launch_tok_reg.now       <= in_ch.now_time;
            launch_tok_reg.wend      <= wend_sat;
            launch_tok_reg.found     <= 1'b0;
            launch_tok_reg.fresh     <= 1'b0;
            launch_tok_reg.malicious <= 1'b0;
            launch_tok_reg.raised    <= 1'b0;
            launch_tok_reg.slot      <= '0;
        end
    end

    // row of table cells
    assign chain_vld[0] = launch_vld_reg;
    assign chain_tok[0] = launch_tok_reg;

    for (genvar gi = 0; gi < TABLE_ENTRIES; gi++)
    begin : g_cell
        pnhfd_cell #(
            .CELL_INDEX (gi)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .max_hellos  (max_hellos_reg),
            .tok_vld_in  (chain_vld[gi]),
            .tok_in      (chain_tok[gi]),
            .tok_vld_out (chain_vld[gi+1]),
            .tok_out     (chain_tok[gi+1]),
            .entry_valid (entry_vld[gi])
        );
    end

    // result from the token leaving the chain
    always_comb
    begin
        if (chain_tok[TABLE_ENTRIES].found)
        begin
            exit_res.malicious     = chain_tok[TABLE_ENTRIES].malicious;
            exit_res.alert_raised  = chain_tok[TABLE_ENTRIES].raised;
            exit_res.lookup_status = chain_tok[TABLE_ENTRIES].fresh ? ST_NEW : ST_EXISTING;
            exit_res.entry_slot    = chain_tok[TABLE_ENTRIES].slot[OSLOT_W-1:0];
        end
        else
        begin
            exit_res.malicious     = 1'b0;
            exit_res.alert_raised  = 1'b0;
            exit_res.lookup_status = ST_FULL;
            exit_res.entry_slot    = '0;
        end
    end

    // result buffer and output register control
    assign pend_move = pend_vld_reg && (!out_vld_reg || out_ch.ready);

    always_comb
    begin
        busy_next     = busy_reg;
        pend_vld_next = pend_vld_reg;
        out_vld_next  = out_vld_reg;
        if (out_vld_reg && out_ch.ready)
        begin
            out_vld_next = 1'b0;
        end
        if (pend_move)
        begin
            pend_vld_next = 1'b0;
            out_vld_next  = 1'b1;
            busy_next     = 1'b0;
        end
        if (chain_vld[TABLE_ENTRIES])
        begin
            pend_vld_next = 1'b1;
        end
        if (in_accept)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain_vld[TABLE_ENTRIES])
        begin
            pend_reg <= exit_res;
        end
        if (pend_move)
        begin
            out_reg <= pend_reg;
        end
    end

    // output beat
    assign out_ch.valid         = out_vld_reg;
    assign out_ch.malicious     = out_reg.malicious;
    assign out_ch.alert_raised  = out_reg.alert_raised;
    assign out_ch.lookup_status = out_reg.lookup_status;
    assign out_ch.entry_slot    = out_reg.entry_slot;

    // checks
    `PNHFD_ASSERT_ALWAYS(a_one_token, $onehot0({pend_vld_reg, chain_vld}),
        "more than one item in flight")
    `PNHFD_ASSERT_IMPLY(a_idle_empty, !busy_reg, (chain_vld == '0) && !pend_vld_reg,
        "work in flight while idle")
    `PNHFD_ASSERT_ALWAYS(a_fill_order,
        (entry_vld & (entry_vld + 1'b1)) == '0,
        "table entries not taken in order")
    `PNHFD_ASSERT_NEXT(a_exit_buffered, chain_vld[TABLE_ENTRIES], pend_vld_reg,
        "result leaving the chain was lost")

endmodule

FILE: verif/hello_flood_checker.sv
// Checker for the hello flood detector: watches the item, result and register ports,
// predicts each result beat from its own copy of the neighbour table and compares.
// Depends on pnhfd_pkg and the pnhfd_in_if / pnhfd_out_if interfaces.
`timescale 1ns / 1ps

module hello_flood_checker
    import pnhfd_pkg::*;
#(
    parameter int unsigned SLOTS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    pnhfd_in_if               in_ch,
    pnhfd_out_if              out_ch,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output int                mismatches,
    output int                pending
);

    typedef struct {
        bit                 used;
        logic [ADDR_W-1:0]  addr;
        phase_t             phase;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  wend;
    } nbr_entry_t;

    nbr_entry_t         nbr_tab [SLOTS];
    int unsigned        nbr_taken;
    logic [WLEN_W-1:0]  win_len;
    logic [MAXH_W-1:0]  max_hellos;
    res_t               awaited_verdicts [$];
    res_t               want;

    // Look up or take the neighbour's entry, apply the item, return the result beat
    function automatic res_t flood_verdict(input logic mode, input logic [ADDR_W-1:0] addr,
                                           input logic [TIME_W-1:0] stamp);
        res_t            r;
        int              s;
        logic            fresh;
        logic [TIME_W:0] sum;
        r = '0;
        s = -1;
        fresh = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (s < 0 && nbr_tab[i].used && nbr_tab[i].addr == addr)
                s = i;
        end
        if (s < 0 && nbr_taken < SLOTS)
        begin
            s = int'(nbr_taken);
            nbr_tab[s].used  = 1'b1;
            nbr_tab[s].addr  = addr;
            nbr_tab[s].phase = PH_IDLE;
            nbr_tab[s].count = '0;
            nbr_tab[s].wend  = '0;
            nbr_taken++;
            fresh = 1'b1;
        end
        if (s < 0)
        begin
            // table full: untracked, nothing changes
            r.lookup_status = ST_FULL;
        end
        else
        begin
            if (mode == MODE_HELLO)
            begin
                // window over once time passes its end; the end itself still counts
                if (nbr_tab[s].phase == PH_WATCH && nbr_tab[s].wend < stamp)
                    nbr_tab[s].phase = PH_IDLE;
                if (nbr_tab[s].phase == PH_IDLE)
                begin
                    sum = {1'b0, stamp} + (TIME_W+1)'(win_len);
                    nbr_tab[s].wend  = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                    nbr_tab[s].phase = PH_WATCH;
                    nbr_tab[s].count = COUNT_W'(1);
                end
                else if (nbr_tab[s].phase == PH_WATCH)
                begin
                    if (nbr_tab[s].count < COUNT_MAX)
                        nbr_tab[s].count++;
                    if (nbr_tab[s].count > {1'b0, max_hellos})
                    begin
                        nbr_tab[s].phase = PH_ALERT;
                        r.alert_raised = 1'b1;
                    end
                end
            end
            r.malicious     = (nbr_tab[s].phase == PH_ALERT);
            r.lookup_status = fresh ? ST_NEW : ST_EXISTING;
            r.entry_slot    = OSLOT_W'(s);
        end
        return r;
    endfunction

    task automatic compare_field(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] got_val);
        if (got_val !== exp_val)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_val, got_val);
        end
    endtask

    // Register copies, prediction on each item beat, comparison on each result beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                nbr_tab[i] = '{1'b0, '0, PH_IDLE, '0, '0};
            nbr_taken  = 0;
            win_len    = WLEN_RESET;
            max_hellos = MAXH_RESET;
            awaited_verdicts.delete();
            mismatches = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_WINDOW_LENGTH: win_len    = cfg_data[WLEN_W-1:0];
                    CFG_MAX_HELLOS:    max_hellos = cfg_data[MAXH_W-1:0];
                    default: ;
                endcase
            end
            // result first, so a beat with nothing awaited cannot pair with a new item
            if (out_ch.valid && out_ch.ready)
            begin
                if (awaited_verdicts.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with nothing awaited, expected none, got slot %0d",
                             $time, out_ch.entry_slot);
                end
                else
                begin
                    want = awaited_verdicts.pop_front();
                    compare_field("malicious", want.malicious, out_ch.malicious);
                    compare_field("alert_raised", want.alert_raised, out_ch.alert_raised);
                    compare_field("lookup_status", want.lookup_status, out_ch.lookup_status);
                    compare_field("entry_slot", want.entry_slot, out_ch.entry_slot);
                end
            end
            if (in_ch.valid && in_ch.ready)
                awaited_verdicts.insert(awaited_verdicts.size(),
                                        flood_verdict(in_ch.mode, in_ch.neighbor_address,
                                                      in_ch.now_time));
            pending <= awaited_verdicts.size();
        end
    end

endmodule

FILE: verif/tb_per_neighbor_hello_flood_detector.sv
// Testbench top for the hello flood detector: clock, reset, register writes and item
// stimulus with random idling; the verdict comes from hello_flood_checker.
// Depends on pnhfd_pkg, the pnhfd interfaces, the detector RTL and the checker.
`timescale 1ns / 1ps

module tb_per_neighbor_hello_flood_detector;
    import pnhfd_pkg::*;

    localparam int unsigned TABLE_ENTRIES = 16;
    localparam int unsigned PHASE_ITEMS   = 272;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam logic        MODE_QUERY    = ~MODE_HELLO;
    localparam logic [TIME_W-1:0] TIME_TOP = '1;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    cfg_idx_t           cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    int                 flood_mismatches;
    int                 beats_in_flight;
    logic               item_taken;
    int                 gap_pct = 0;
    int                 stall_pct = 0;
    bit                 start_hold = 1'b0;
    int unsigned        cycle_count = 0;
    logic [ADDR_W-1:0]  nbr_pool [$];

    pnhfd_in_if  in_ch ();
    pnhfd_out_if out_ch ();

    per_neighbor_hello_flood_detector #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hello_flood_checker #(
        .SLOTS (TABLE_ENTRIES)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (flood_mismatches),
        .pending    (beats_in_flight)
    );

    always #6 clk = ~clk;

    // item beat seen at the last rising edge
    always @(posedge clk)
        item_taken <= in_ch.valid && in_ch.ready;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        int unsigned hold_left;
        bit          hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (start_hold && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ch.ready = 1'b0;
                hold_left--;
            end
            else
                out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Offer one item beat (after random idle cycles) and wait until it is taken
    task automatic offer(input logic mode, input logic [ADDR_W-1:0] addr,
                         input logic [TIME_W-1:0] stamp);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid            = 1'b1;
        in_ch.mode             = mode;
        in_ch.neighbor_address = addr;
        in_ch.now_time         = stamp;
        @(negedge clk);
        while (!item_taken)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // stop offering and wait for every result beat to come back
    task automatic settle();
        in_ch.valid = 1'b0;
        while (beats_in_flight != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] clock_us;
        logic [TIME_W-1:0] stamp;
        logic [TIME_W:0]   later;
        logic [WLEN_W-1:0] win;
        logic [MAXH_W-1:0] maxh;
        logic              mode_bit;
        int unsigned       tick;
        int unsigned       advance;
        int unsigned       pick;
        int unsigned       reach;

        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = CFG_WINDOW_LENGTH;
        cfg_data               = '0;
        in_ch.valid            = 1'b0;
        in_ch.mode             = MODE_HELLO;
        in_ch.neighbor_address = '0;
        in_ch.now_time         = '0;
        clock_us               = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: short window, one hello allowed
        write_reg(CFG_WINDOW_LENGTH, 32'd100);
        write_reg(CFG_MAX_HELLOS, 32'd1);
        offer(MODE_HELLO, 32'h0000_0000, 48'd0);      // new entry, window to 100
        offer(MODE_HELLO, 32'h0000_0000, 48'd100);    // exactly at window end: alert
        offer(MODE_QUERY, 32'h0000_0000, 48'd100);
        offer(MODE_QUERY, 32'hFFFF_FFFF, 48'd100);    // query still takes an entry
        offer(MODE_HELLO, 32'hFFFF_FFFF, 48'd101);
        offer(MODE_HELLO, 32'hFFFF_FFFF, 48'd202);    // past the end: count restarts
        offer(MODE_HELLO, 32'hFFFF_FFFF, 48'd202);
        settle();

        // Directed: widest window, zero maximum, window end saturating
        write_reg(CFG_WINDOW_LENGTH, 32'hFFFF_FFFF);
        write_reg(CFG_MAX_HELLOS, 32'd0);
        offer(MODE_HELLO, 32'hC0A8_0001, 48'd1000);   // first hello is not checked
        offer(MODE_HELLO, 32'hC0A8_0001, 48'd1000);   // second one alerts
        offer(MODE_HELLO, 32'h0A00_0002, TIME_TOP - 48'd6);
        offer(MODE_QUERY, 32'h0A00_0002, TIME_TOP);
        offer(MODE_HELLO, 32'h0A00_0002, TIME_TOP);
        settle();
        nbr_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hC0A8_0001, 32'h0A00_0002};

        // Random phases: each with its own registers and idling pattern
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin win = 32'd1;    maxh = 8'd255; tick = 1;    gap_pct = 0;  stall_pct = 0;  end
                1: begin win = 32'd1000; maxh = 8'd20;  tick = 100;  gap_pct = 55; stall_pct = 0;  end
                2: begin win = 32'd300;  maxh = 8'd3;   tick = 60;   gap_pct = 0;  stall_pct = 55; end
                default:
                   begin win = '1;       maxh = 8'd0;   tick = 1000; gap_pct = 7;  stall_pct = 7;  end
            endcase
            write_reg(CFG_WINDOW_LENGTH, win);
            write_reg(CFG_MAX_HELLOS, CFG_W'(maxh));
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // long receiver hold-off while items keep coming
                if (p == 0 && k == 60)
                    start_hold = 1'b1;

                // neighbour: mostly tracked ones, now and then a new address
                pick = $urandom_range(0, 99);
                if (nbr_pool.size() == 0 || pick < 6)
                begin
                    addr = $urandom;
                    nbr_pool.insert(nbr_pool.size(), addr);
                end
                else if (pick < 80)
                begin
                    reach = (nbr_pool.size() < TABLE_ENTRIES) ? nbr_pool.size() : TABLE_ENTRIES;
                    addr  = nbr_pool[$urandom_range(0, reach - 1)];
                end
                else
                    addr = nbr_pool[$urandom_range(0, nbr_pool.size() - 1)];

                // time: mostly creeping forward on the scale of the window
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    advance = 0;
                else if (pick < 80)
                    advance = $urandom_range(1, tick);
                else if (pick < 96)
                    advance = $urandom_range(tick, 20 * tick);
                else
                    advance = $urandom;
                later    = {1'b0, clock_us} + (TIME_W+1)'(advance);
                clock_us = later[TIME_W] ? TIME_TOP : later[TIME_W-1:0];
                stamp    = clock_us;
                if ($urandom_range(0, 99) < 3)
                    stamp = {16'($urandom), $urandom};   // stray time stamp

                mode_bit = ($urandom_range(0, 99) < 70) ? MODE_HELLO : MODE_QUERY;
                offer(mode_bit, addr, stamp);
            end
            settle();
        end

        repeat (3 * TABLE_ENTRIES) @(negedge clk);
        if (flood_mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
